// ===== rtl/fbdr_pkg.sv =====
package fbdr_pkg;

    localparam int MAX_WIDTH      = 128;
    localparam int MAX_HEIGHT     = 128;
    localparam int MAX_FLUSH_ROWS = 64;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_FILL  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_CLEAN   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_FILL,
        S_READ,
        S_SEARCH,
        S_FLUSH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  x_start;
        logic [6:0]  y_start;
        logic [6:0]  x_end;
        logic [6:0]  y_end;
        logic [15:0] pixel_color;
        logic [6:0]  max_rows;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  flushed_row;
        logic        run_last;
        logic [15:0] read_color;
        logic [7:0]  rows_pending;
    } t_out_item;

endpackage

// ===== rtl/fbdr_ram.sv =====
module fbdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/framebuffer_dirty_row_flush.sv =====
// channel  | ports                          | beat
// command  | i_start, o_busy, i_cmd         | start high while busy low
// result   | o_result_valid, o_result       | one cycle per result, no stall
// config   | psel..pready (apb)             | write at access with pready
// write pixel, read pixel, fill: busy while the command runs, result as busy
// drops; a rejected beat answers in the next cycle without busy. flush: searches
// rows up to the first dirty one (rows in use if none), then sizes the run row by
// row and emits it row by row. after reset a clearing pass zeroes the pixel
// memory with busy high; the receiver cannot stall.
module framebuffer_dirty_row_flush (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  fbdr_pkg::t_in_item   i_cmd,
    output logic                 o_result_valid,
    output fbdr_pkg::t_out_item  o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import fbdr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [7:0] r_cw, r_ch;
    t_state     r_state, n_state;
    t_in_item   r_cmd, n_cmd;
    logic [AW:0] r_addr, n_addr;
    logic [6:0] r_x, n_x, r_y, n_y;
    logic [6:0] r_cnt, n_cnt;
    logic [7:0] r_searched, n_searched;
    logic [7:0] r_total, n_total;
    logic [6:0] r_cursor, n_cursor;
    logic [6:0] r_first, n_first;
    logic       r_vld, n_vld;
    t_out_item  r_res, n_res;

    // effective dimensions
    logic [8:0] w, h;
    always_comb begin
        w = (r_cw == 8'd0) ? 9'd1 : ((9'(r_cw) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(r_cw));
        h = (r_ch == 8'd0) ? 9'd1 : ((9'(r_ch) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(r_ch));
    end

    // apb
    assign pready = 1'b1;
    always_comb begin
        unique case (t_reg_idx'({1'b0, paddr[2]}))
            REG_WIDTH: prdata = {24'd0, r_cw};
            default:   prdata = {24'd0, r_ch};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= 8'd128;
            r_ch <= 8'd128;
        end else if (psel && penable && pwrite && pready) begin
            if (t_reg_idx'({1'b0, paddr[2]}) == REG_WIDTH) r_cw <= pwdata[7:0];
            else r_ch <= pwdata[7:0];
        end
    end

    // memories
    logic          pix_we;
    logic [AW-1:0] pix_wa, pix_ra;
    logic [15:0]   pix_wd, pix_rd;
    logic          dty_we;
    logic [HW-1:0] dty_wa, dty_ra;
    logic          dty_wd, dty_rd;

    fbdr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pix (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_wa), .i_wdata(pix_wd),
        .i_raddr(pix_ra), .o_rdata(pix_rd)
    );
    // dirty bits stored inverted so that a cleared memory reads dirty
    logic dty_rd_n;
    fbdr_ram #(.WIDTH(1), .DEPTH(MAX_HEIGHT)) u_dty (
        .i_clk(i_clk), .i_we(dty_we), .i_waddr(dty_wa), .i_wdata(~dty_wd),
        .i_raddr(dty_ra), .o_rdata(dty_rd_n)
    );
    assign dty_rd = ~dty_rd_n;

    // the clearing pass also covers the dirty memory
    logic [AW-1:0] cmd_addr, run_addr;
    assign cmd_addr = AW'(32'(i_cmd.y_start) * 32'(w) + 32'(i_cmd.x_start));
    assign run_addr = AW'(32'(r_y) * 32'(w) + 32'(r_x));

    // dirty-mark update helper: r_mark_row marked, read-before-write via r_mark_pend
    logic mark_pend, r_mark_pend;
    logic [6:0] r_mark_row;

    assign o_busy         = (r_state != S_IDLE) || r_mark_pend;
    assign o_result_valid = r_vld;
    assign o_result       = r_res;

    logic accept;
    assign accept = i_start && !o_busy;

    logic bad_pt, bad_rect;
    assign bad_pt = 9'(i_cmd.x_start) >= w || 9'(i_cmd.y_start) >= h;
    assign bad_rect = bad_pt || 9'(i_cmd.x_end) >= w || 9'(i_cmd.y_end) >= h
                   || i_cmd.x_start > i_cmd.x_end || i_cmd.y_start > i_cmd.y_end;

    logic [7:0] nxt_row;

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_addr = r_addr; n_x = r_x; n_y = r_y;
        n_cnt = r_cnt; n_searched = r_searched; n_total = r_total;
        n_cursor = r_cursor; n_first = r_first; n_vld = 1'b0; n_res = r_res;
        pix_we = 1'b0; pix_wa = run_addr; pix_wd = r_cmd.pixel_color; pix_ra = cmd_addr;
        dty_we = 1'b0; dty_wa = HW'(r_y); dty_wd = 1'b1; dty_ra = HW'(r_y);
        mark_pend = 1'b0;
        nxt_row = {1'b0, r_y} + 8'd1;
        unique case (r_state)
            S_CLEAR: begin
                pix_we = 1'b1;
                pix_wa = r_addr[AW-1:0];
                pix_wd = 16'd0;
                if (r_addr[AW-1:0] < AW'(MAX_HEIGHT) || AW < HW) begin
                    dty_we = 1'b1;
                    dty_wa = HW'(r_addr);
                end
                n_addr = r_addr + (AW+1)'(1);
                if (r_addr == (AW+1)'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                // a pending mark: dirty bit read last cycle
                if (r_mark_pend) begin
                    dty_we = 1'b1;
                    dty_wa = HW'(r_mark_row);
                    if (!dty_rd) n_total = r_total + 8'd1;
                    if (r_cmd.func == FUNC_FILL) begin
                        n_vld = 1'b1;
                        n_res = '{ST_OK, 7'd0, 1'b1, 16'd0, n_total};
                    end else begin
                        n_vld = 1'b1;
                        n_res = '{ST_OK, 7'd0, 1'b1, 16'd0, n_total};
                    end
                end else if (accept) begin
                    n_cmd = i_cmd;
                    n_x = i_cmd.x_start;
                    n_y = i_cmd.y_start;
                    unique case (t_func'(i_cmd.func))
                        FUNC_WRITE: begin
                            if (bad_pt) begin
                                n_vld = 1'b1;
                                n_res = '{ST_BAD_ARG, 7'd0, 1'b1, 16'd0, r_total};
                            end else begin
                                pix_we = 1'b1;
                                pix_wa = cmd_addr;
                                pix_wd = i_cmd.pixel_color;
                                dty_ra = HW'(i_cmd.y_start);
                                mark_pend = 1'b1;
                            end
                        end
                        FUNC_READ: begin
                            if (bad_pt) begin
                                n_vld = 1'b1;
                                n_res = '{ST_BAD_ARG, 7'd0, 1'b1, 16'd0, r_total};
                            end else n_state = S_READ;
                        end
                        FUNC_FILL: begin
                            if (bad_rect) begin
                                n_vld = 1'b1;
                                n_res = '{ST_BAD_ARG, 7'd0, 1'b1, 16'd0, r_total};
                            end else n_state = S_FILL;
                        end
                        default: begin
                            if (i_cmd.max_rows == 7'd0) begin
                                n_vld = 1'b1;
                                n_res = '{ST_BAD_SIZE, 7'd0, 1'b1, 16'd0, r_total};
                            end else begin
                                n_y = (9'(r_cursor) < h) ? r_cursor : 7'd0;
                                n_cnt = (i_cmd.max_rows > 7'(MAX_FLUSH_ROWS))
                                      ? 7'(MAX_FLUSH_ROWS) : i_cmd.max_rows;
                                n_searched = 8'd0;
                                n_state = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_vld = 1'b1;
                n_res = '{ST_OK, 7'd0, 1'b1, pix_rd, r_total};
                n_state = S_IDLE;
            end
            S_FILL: begin
                // one pixel a cycle; the row's mark is read at its last pixel and written via r_mark_pend
                pix_we = 1'b1;
                if (r_x == r_cmd.x_end) begin
                    n_x = r_cmd.x_start;
                    dty_ra = HW'(r_y);
                    if (r_y == r_cmd.y_end) begin
                        mark_pend = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        mark_pend = 1'b1;
                        n_y = r_y + 7'd1;
                    end
                end else n_x = r_x + 7'd1;
                if (r_mark_pend) begin
                    dty_we = 1'b1;
                    dty_wa = HW'(r_mark_row);
                    if (!dty_rd) n_total = r_total + 8'd1;
                end
            end
            S_SEARCH: begin
                // r_searched==0: read issued; later compare last read
                dty_ra = HW'(r_y);
                n_searched = r_searched + 8'd1;
                if (r_searched != 8'd0) begin
                    if (dty_rd) begin
                        n_state = S_FLUSH;
                        n_first = r_y;
                        n_searched = 8'd1;
                        dty_ra = HW'(nxt_row);
                    end else if (9'(r_searched) >= h) begin
                        n_vld = 1'b1;
                        n_res = '{ST_CLEAN, 7'd0, 1'b1, 16'd0, r_total};
                        n_state = S_IDLE;
                    end else begin
                        n_y = (9'(nxt_row) == h) ? 7'd0 : nxt_row[6:0];
                        dty_ra = HW'(n_y);
                    end
                end
            end
            S_FLUSH: begin
                // size the run: r_y ends it so far, dty_rd is the mark of the next row
                if (9'(nxt_row) >= h || r_searched == {1'b0, r_cnt} || !dty_rd) begin
                    n_cursor = (9'(nxt_row) >= h) ? 7'd0 : nxt_row[6:0];
                    n_total = r_total - r_searched;
                    n_y = r_first;
                    n_state = S_EMIT;
                end else begin
                    n_y = nxt_row[6:0];
                    n_searched = r_searched + 8'd1;
                    dty_ra = HW'(r_y + 7'd2);
                end
            end
            S_EMIT: begin
                // one row a cycle, each mark cleared as its beat goes out
                dty_we = 1'b1;
                dty_wd = 1'b0;
                dty_wa = HW'(r_y);
                n_vld = 1'b1;
                n_res = '{ST_OK, r_y, 1'b0, 16'd0, r_total};
                n_y = r_y + 7'd1;
                n_searched = r_searched - 8'd1;
                if (r_searched == 8'd1) begin
                    n_res.run_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_total <= 8'(MAX_HEIGHT);
            r_cursor <= 7'd0;
            r_vld <= 1'b0;
            r_mark_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_total <= n_total;
            r_cursor <= n_cursor;
            r_mark_pend <= mark_pend;
            r_vld <= n_vld;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_x <= n_x;
        r_y <= n_y;
        r_cnt <= n_cnt;
        r_first <= n_first;
        r_searched <= n_searched;
        r_mark_row <= (r_state == S_FILL) ? r_y : n_y;
    end
endmodule
